### design/fahtik_pkg.sv
// Shared types, constants and tables for the five-axis inverse kinematics block.
package fahtik_pkg;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_TCP_ENABLE = 3'd0;
  localparam logic [2:0] REG_PIVOT_Z    = 3'd1;
  localparam logic [2:0] REG_TOOL_X     = 3'd2;
  localparam logic [2:0] REG_TOOL_Y     = 3'd3;
  localparam logic [2:0] REG_TOOL_Z     = 3'd4;

  localparam int PosW   = 24;
  localparam int AngW   = 20;
  localparam int TrigW  = 34;  // Q30 cos/sin with headroom for CORDIC growth
  localparam int QBits  = 30;

  localparam logic signed [TrigW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [PosW-1:0]  PosMax = 24'sd8388607;
  localparam logic signed [PosW-1:0]  PosMin = -24'sd8388608;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic signed [33:0] atan_val(input logic [4:0] i);
    logic signed [33:0] r;
    begin
      case (i)
        5'd0: r = 34'sd536870912;   5'd1: r = 34'sd316933406;
        5'd2: r = 34'sd167458907;   5'd3: r = 34'sd85004756;
        5'd4: r = 34'sd42667331;    5'd5: r = 34'sd21354465;
        5'd6: r = 34'sd10679838;    5'd7: r = 34'sd5340245;
        5'd8: r = 34'sd2670163;     5'd9: r = 34'sd1335087;
        5'd10: r = 34'sd667544;     5'd11: r = 34'sd333772;
        5'd12: r = 34'sd166886;     5'd13: r = 34'sd83443;
        5'd14: r = 34'sd41722;      5'd15: r = 34'sd20861;
        5'd16: r = 34'sd10430;      5'd17: r = 34'sd5215;
        5'd18: r = 34'sd2608;       5'd19: r = 34'sd1304;
        5'd20: r = 34'sd652;        5'd21: r = 34'sd326;
        5'd22: r = 34'sd163;        5'd23: r = 34'sd81;
        5'd24: r = 34'sd41;         5'd25: r = 34'sd20;
        5'd26: r = 34'sd10;         5'd27: r = 34'sd5;
        5'd28: r = 34'sd3;          5'd29: r = 34'sd1;
        5'd30: r = 34'sd1;
        default: r = 34'sd0;
      endcase
      return r;
    end
  endfunction

  // Pose fields that travel alongside the trig pipeline.
  typedef struct packed {
    logic                    tcp;
    logic signed [PosW-1:0]  x;
    logic signed [PosW-1:0]  y;
    logic signed [PosW-1:0]  z;
    logic signed [AngW-1:0]  tilt;
    logic signed [AngW-1:0]  table_a;
  } pose_t;

endpackage

### design/five_axis_head_table_inverse_kin.sv
// Five-axis head-table inverse kinematics: angle reduction, CORDIC pipelines and output math.
// One item is accepted every cycle.
// The depth grows with the unrolled CORDIC rotation stages, one per register stage.
// busy stays low, so start may be held high each cycle; done pulses for one cycle per item.
// Synchronous active-high rst clears the valid bits and all configuration registers to zero.
// Configuration is sampled when an item enters and travels with it down the pipeline.
module five_axis_head_table_inverse_kin #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [4:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [fahtik_pkg::PosW-1:0] cart_x,
  input  logic signed [fahtik_pkg::PosW-1:0] cart_y,
  input  logic signed [fahtik_pkg::PosW-1:0] cart_z,
  input  logic signed [fahtik_pkg::AngW-1:0] tilt_angle,
  input  logic signed [fahtik_pkg::AngW-1:0] table_angle,
  output logic                               done,
  output logic signed [fahtik_pkg::PosW-1:0] joint_x,
  output logic signed [fahtik_pkg::PosW-1:0] joint_y,
  output logic signed [fahtik_pkg::PosW-1:0] joint_z,
  output logic signed [fahtik_pkg::AngW-1:0] joint_tilt,
  output logic signed [fahtik_pkg::AngW-1:0] joint_table
);
  import fahtik_pkg::*;

  localparam int NS = CORDIC_STAGES;
  localparam int PreS = 5;               // reduction stages before CORDIC
  localparam int Depth = PreS + NS + 3;  // last stage carrying pose data

  // Configuration registers.
  logic                   tcp_enable;
  logic signed [PosW-1:0] pivot_offset_z, tool_offset_x, tool_offset_y, tool_offset_z;
  logic                   wr_en;
  logic [2:0]             reg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      tcp_enable     <= 1'b0;
      pivot_offset_z <= '0;
      tool_offset_x  <= '0;
      tool_offset_y  <= '0;
      tool_offset_z  <= '0;
    end else if (wr_en) begin
      case (reg_idx)
        REG_TCP_ENABLE: tcp_enable     <= pwdata[0];
        REG_PIVOT_Z:    pivot_offset_z <= pwdata[PosW-1:0];
        REG_TOOL_X:     tool_offset_x  <= pwdata[PosW-1:0];
        REG_TOOL_Y:     tool_offset_y  <= pwdata[PosW-1:0];
        REG_TOOL_Z:     tool_offset_z  <= pwdata[PosW-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (reg_idx)
      REG_TCP_ENABLE: prdata = {31'd0, tcp_enable};
      REG_PIVOT_Z:    prdata = {{8{pivot_offset_z[PosW-1]}}, pivot_offset_z};
      REG_TOOL_X:     prdata = {{8{tool_offset_x[PosW-1]}}, tool_offset_x};
      REG_TOOL_Y:     prdata = {{8{tool_offset_y[PosW-1]}}, tool_offset_y};
      REG_TOOL_Z:     prdata = {{8{tool_offset_z[PosW-1]}}, tool_offset_z};
      default:        prdata = '0;
    endcase
  end

  // Valid bits and pose/offset payload for every stage.
  logic [Depth:0] vld;
  pose_t          pose [Depth+1];
  logic signed [PosW:0] px [Depth+1];
  logic signed [PosW:0] py [Depth+1];
  logic signed [PosW:0] len [Depth+1];
  logic signed [PosW:0] zoff [Depth+1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else     vld <= {vld[Depth-1:0], start};
  end

  // Stage 0 capture: subtract tool offsets from x and y, form pivot length and pivot-relative z.
  always_ff @(posedge clk) begin
    pose[0] <= '{tcp: tcp_enable, x: cart_x, y: cart_y, z: cart_z,
                 tilt: tilt_angle, table_a: table_angle};
    px[0]   <= (PosW+1)'(cart_x) - (PosW+1)'(tool_offset_x);
    py[0]   <= (PosW+1)'(cart_y) - (PosW+1)'(tool_offset_y);
    len[0]  <= (PosW+1)'(pivot_offset_z) - (PosW+1)'(tool_offset_z);
    zoff[0] <= (PosW+1)'(cart_z) - (PosW+1)'(pivot_offset_z);
  end

  for (genvar s = 1; s <= Depth; s++) begin : g_carry
    always_ff @(posedge clk) begin
      pose[s] <= pose[s-1];
      px[s]   <= px[s-1];
      py[s]   <= py[s-1];
      len[s]  <= len[s-1];
      zoff[s] <= zoff[s-1];
    end
  end

  // Angle reduction, two lanes: lane 0 is tilt, lane 1 is table.
  // The binary angle is a = floor((r*2^32 + 180000)/360000) for the residue r.
  // Since 2^32 = 11930*360000 + 167296, a = 11930*r + floor((5228*r + 5625)/11250),
  // and that last quotient is a reciprocal multiply of the halved numerator by 1/5625.
  localparam logic [13:0] TurnWhole = 14'd11930;
  localparam logic [12:0] FracMul   = 13'd5228;
  localparam logic [12:0] FracBias  = 13'd5625;
  localparam logic [30:0] RecipK    = 31'd1563749871;  // ceil(2^43/5625)

  logic signed [AngW-1:0] ain [2];
  logic [18:0]            r1 [2];       // residue in [0, 360000)
  logic [31:0]            whole [2];
  logic [29:0]            n2 [2];
  logic [31:0]            whole_d [2];
  logic [60:0]            prod [2];
  logic signed [33:0]     ba [2];       // binary angle, 32-bit signed range
  logic signed [33:0]     fa [2];
  logic                   fneg [2];

  assign ain[0] = pose[0].tilt;
  assign ain[1] = pose[0].table_a;

  for (genvar l = 0; l < 2; l++) begin : g_red
    logic signed [21:0] t0;
    logic signed [21:0] t1;
    logic [30:0]        frac;
    // One conditional add/subtract of 360000 brings |a| below 360000,
    // then negatives wrap up into [0, 360000).
    always_comb begin
      t0 = 22'(ain[l]);
      if (t0 >= 22'sd360000)       t1 = t0 - 22'sd360000;
      else if (t0 <= -22'sd360000) t1 = t0 + 22'sd360000;
      else                         t1 = t0;
      if (t1 < 0) t1 = t1 + 22'sd360000;
    end
    // Stage 1: reduced residue.
    always_ff @(posedge clk) begin
      r1[l] <= t1[18:0];
    end
    // Stage 2: whole turns part and the halved fraction numerator.
    always_comb begin
      frac = 31'(r1[l]) * 31'(FracMul) + 31'(FracBias);
    end
    always_ff @(posedge clk) begin
      whole[l] <= 32'(r1[l]) * 32'(TurnWhole);
      n2[l]    <= frac[30:1];
    end
    // Stage 3: reciprocal multiply, exact for every numerator below 2^30.
    always_ff @(posedge clk) begin
      prod[l]    <= 61'(n2[l]) * 61'(RecipK);
      whole_d[l] <= whole[l];
    end
    // Stage 4: the upper half of the turn reads as a negative angle.
    always_ff @(posedge clk) begin
      ba[l] <= 34'($signed(whole_d[l] + 32'(prod[l][60:43])));
    end
    // Stage 5: fold into [-90, 90] degrees.
    always_ff @(posedge clk) begin
      if (ba[l] > 34'sh040000000) begin
        fa[l] <= ba[l] - 34'sh080000000; fneg[l] <= 1'b1;
      end else if (ba[l] < -34'sh040000000) begin
        fa[l] <= ba[l] + 34'sh080000000; fneg[l] <= 1'b1;
      end else begin
        fa[l] <= ba[l]; fneg[l] <= 1'b0;
      end
    end
  end

  // CORDIC rotation pipelines, one stage per iteration.
  logic signed [TrigW-1:0] cx [2][NS+1];
  logic signed [TrigW-1:0] cy [2][NS+1];
  logic signed [33:0]      ca [2][NS+1];
  logic                    cn [2][NS+1];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    always_comb begin
      cx[l][0] = CordicGain;
      cy[l][0] = '0;
      ca[l][0] = fa[l];
      cn[l][0] = fneg[l];
    end
    for (genvar i = 0; i < NS; i++) begin : g_it
      always_ff @(posedge clk) begin
        if (ca[l][i] >= 0) begin
          cx[l][i+1] <= cx[l][i] - (cy[l][i] >>> i);
          cy[l][i+1] <= cy[l][i] + (cx[l][i] >>> i);
          ca[l][i+1] <= ca[l][i] - atan_val(5'(i));
        end else begin
          cx[l][i+1] <= cx[l][i] + (cy[l][i] >>> i);
          cy[l][i+1] <= cy[l][i] - (cx[l][i] >>> i);
          ca[l][i+1] <= ca[l][i] + atan_val(5'(i));
        end
        cn[l][i+1] <= cn[l][i];
      end
    end
  end

  // Stage after CORDIC: apply fold sign.
  logic signed [TrigW-1:0] cb, sb, cc, sc;
  always_ff @(posedge clk) begin
    cb <= cn[0][NS] ? -cx[0][NS] : cx[0][NS];
    sb <= cn[0][NS] ? -cy[0][NS] : cy[0][NS];
    cc <= cn[1][NS] ? -cx[1][NS] : cx[1][NS];
    sc <= cn[1][NS] ? -cy[1][NS] : cy[1][NS];
  end

  // Products, each 25 x 34 bits, registered.
  localparam int M = PosW + 1 + TrigW;
  localparam int PI = PreS + NS + 1;  // pose index aligned with cb/sb
  logic signed [M-1:0] p_xc, p_ys, p_ls, p_yc, p_xs, p_lc;
  logic signed [M-1:0] zq;
  always_ff @(posedge clk) begin
    p_xc <= M'(px[PI]) * M'(cc);
    p_ys <= M'(py[PI]) * M'(sc);
    p_ls <= M'(len[PI]) * M'(sb);
    p_yc <= M'(py[PI]) * M'(cc);
    p_xs <= M'(px[PI]) * M'(sc);
    p_lc <= M'(len[PI]) * M'(cb);
    zq   <= M'(zoff[PI]) <<< QBits;
  end

  // Sums with the rounding bias.
  localparam int SW = M + 2;
  localparam logic signed [SW-1:0] Half = SW'(1) <<< (QBits-1);
  logic signed [SW-1:0] sx, sy, sz;
  always_ff @(posedge clk) begin
    sx <= SW'(p_xc) + SW'(p_ys) + SW'(p_ls) + Half;
    sy <= SW'(p_yc) - SW'(p_xs) + Half;
    sz <= SW'(zq) + SW'(p_lc) + Half;
  end

  // Floor shift and saturate.
  function automatic logic signed [PosW-1:0] sat_q(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    begin
      t = v >>> QBits;
      if (t > SW'(PosMax))      return PosMax;
      else if (t < SW'(PosMin)) return PosMin;
      else                      return t[PosW-1:0];
    end
  endfunction

  // Output register.
  localparam int OI = PI + 2;
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vld[OI];
    joint_tilt  <= pose[OI].tilt;
    joint_table <= pose[OI].table_a;
    if (pose[OI].tcp) begin
      joint_x <= sat_q(sx);
      joint_y <= sat_q(sy);
      joint_z <= sat_q(sz);
    end else begin
      joint_x <= pose[OI].x;
      joint_y <= pose[OI].y;
      joint_z <= pose[OI].z;
    end
  end

`ifndef SYNTHESIS
  // done is registered from the valid bit of the last payload stage.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    vld[OI] |=> done) else $error("done missing after pipeline");
  // The block never refuses an item.
  a_nobusy: assert property (@(posedge clk) !busy) else $error("busy raised");
  // Every item keeps its tilt angle at the output.
  a_angles: assert property (@(posedge clk) disable iff (rst)
    vld[OI] |=> joint_tilt == $past(pose[OI].tilt)) else $error("tilt corrupted");
`endif

endmodule
